// ===== src/icymd_pkg.sv =====
`default_nettype none
package icymd_pkg;

  // Result phase codes
  localparam logic [2:0] CODE_HEADER = 3'd0;
  localparam logic [2:0] CODE_AUDIO  = 3'd1;
  localparam logic [2:0] CODE_LEN    = 3'd2;
  localparam logic [2:0] CODE_META   = 3'd3;
  localparam logic [2:0] CODE_ERROR  = 3'd4;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam int HEADER_LIMIT_DEF = 16384;

  localparam int INTERVAL_W = 24;
  localparam int META_W     = 12;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 32;

  localparam logic [CFG_AW-1:0] ADDR_META_INTERVAL = '0;

  typedef struct packed {
    logic [7:0] data;
    logic       payload;
    logic [2:0] code;
    logic       hend;
  } icymd_res_t;

endpackage
`default_nettype wire

// ===== src/icymd_core.sv =====
`default_nettype none
module icymd_core
  import icymd_pkg::*;
#(
  parameter int HEADER_LIMIT = HEADER_LIMIT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [7:0]            in_byte,
  input  wire logic [INTERVAL_W-1:0] meta_interval,
  output icymd_res_t                 res
);

  localparam int HC_W = $clog2(HEADER_LIMIT + 1);

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_AUDIO,
    ST_META,
    ST_ERROR
  } state_t;

  state_t                state_r, state_nxt;
  logic [2:0]            match_r, match_nxt;
  logic [HC_W-1:0]       hcount_r, hcount_nxt;
  logic [INTERVAL_W-1:0] audio_left_r, audio_left_nxt;
  logic [META_W-1:0]     meta_left_r, meta_left_nxt;

  logic [META_W-1:0]     meta_dec;

  always_comb begin
    state_nxt      = state_r;
    match_nxt      = match_r;
    hcount_nxt     = hcount_r;
    audio_left_nxt = audio_left_r;
    meta_left_nxt  = meta_left_r;
    meta_dec       = meta_left_r;
    res.data       = in_byte;
    res.payload    = 1'b0;
    res.code       = CODE_HEADER;
    res.hend       = 1'b0;

    case (state_r)
      ST_HEADER: begin
        if (in_byte == CH_CR && (match_r == 3'd0 || match_r == 3'd2)) begin
          match_nxt = match_r + 3'd1;
        end else if (in_byte == CH_LF && (match_r == 3'd1 || match_r == 3'd3)) begin
          match_nxt = match_r + 3'd1;
        end else begin
          match_nxt = 3'd0;
        end
        if (match_nxt == 3'd4) begin
          res.hend       = 1'b1;
          match_nxt      = 3'd0;
          state_nxt      = ST_AUDIO;
          audio_left_nxt = meta_interval;
        end else if (hcount_r >= HC_W'(HEADER_LIMIT)) begin
          res.code  = CODE_ERROR;
          state_nxt = ST_ERROR;
        end else begin
          hcount_nxt = hcount_r + 1'b1;
        end
      end
      ST_ERROR: begin
        res.code = CODE_ERROR;
      end
      ST_AUDIO, ST_META: begin
        if (meta_interval == '0) begin
          // stripping off: pass through, drop any block in progress
          res.code      = CODE_AUDIO;
          res.payload   = 1'b1;
          state_nxt     = ST_AUDIO;
          meta_left_nxt = '0;
        end else if (state_r == ST_AUDIO) begin
          if (audio_left_r == '0) begin
            res.code      = CODE_LEN;
            meta_left_nxt = {in_byte, 4'b0000};
            if (in_byte == 8'd0) begin
              audio_left_nxt = meta_interval;
            end else begin
              state_nxt = ST_META;
            end
          end else begin
            res.code       = CODE_AUDIO;
            res.payload    = 1'b1;
            audio_left_nxt = audio_left_r - 1'b1;
          end
        end else begin
          res.code = CODE_META;
          if (meta_left_r != '0) begin
            meta_dec = meta_left_r - 1'b1;
          end
          meta_left_nxt = meta_dec;
          if (meta_dec == '0) begin
            audio_left_nxt = meta_interval;
            state_nxt      = ST_AUDIO;
          end
        end
      end
      default: begin
        res.code = CODE_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_HEADER;
      match_r      <= 3'd0;
      hcount_r     <= '0;
      audio_left_r <= '0;
      meta_left_r  <= '0;
    end else if (accept) begin
      state_r      <= state_nxt;
      match_r      <= match_nxt;
      hcount_r     <= hcount_nxt;
      audio_left_r <= audio_left_nxt;
      meta_left_r  <= meta_left_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/icy_metadata_stripper.sv =====
// The result of an accepted byte is registered into the output buffer: the main entry, or the skid entry if stalled.
// One byte per cycle while in_stall is low; the parser state updates on each accepted byte.
// A two-entry output buffer (result register plus skid) decouples the sides;
// in_stall rises only when both entries hold results.
// Reset (rst_n low, synchronous): header phase, all counters zero,
// meta_interval zero, output buffer empty.
`default_nettype none
module icy_metadata_stripper
  import icymd_pkg::*;
#(
  parameter int HEADER_LIMIT = HEADER_LIMIT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input beats
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_byte,
  // result beats
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_is_payload,
  output logic [2:0]             out_phase_code,
  output logic                   out_header_end,
  // APB config port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  // ---------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------
  logic [INTERVAL_W-1:0] meta_interval_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_interval_r <= '0;
    end else if (psel && penable && pwrite && paddr == ADDR_META_INTERVAL) begin
      meta_interval_r <= pwdata[INTERVAL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_META_INTERVAL) begin
      prdata = CFG_DW'(meta_interval_r);
    end
  end

  // ---------------------------------------------------------------
  // Parser: state advances on every accepted beat
  // ---------------------------------------------------------------
  logic       accept;
  icymd_res_t res;

  assign accept = in_valid && !in_stall;

  icymd_core #(
    .HEADER_LIMIT (HEADER_LIMIT)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_byte       (in_byte),
    .meta_interval (meta_interval_r),
    .res           (res)
  );

  // ---------------------------------------------------------------
  // Output buffer: main result register plus one skid entry.
  // Skid fills only when a beat arrives while the main entry is stalled.
  // ---------------------------------------------------------------
  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  icymd_res_t main_r, skid_r;
  logic       drain;
  logic       load_main_res, load_main_skid, load_skid;

  assign drain    = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_main_res  = 1'b0;
    load_main_skid = 1'b0;
    load_skid      = 1'b0;
    if (!out_valid_r) begin
      if (accept) begin
        load_main_res = 1'b1;
        out_valid_nxt = 1'b1;
      end
    end else if (drain) begin
      if (skid_valid_r) begin
        load_main_skid = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (accept) begin
        load_main_res = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      // main stalled, park the new result
      load_skid      = 1'b1;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main_res) begin
      main_r <= res;
    end else if (load_main_skid) begin
      main_r <= skid_r;
    end
    if (load_skid) begin
      skid_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = main_r.data;
  assign out_is_payload = main_r.payload;
  assign out_phase_code = main_r.code;
  assign out_header_end = main_r.hend;

endmodule
`default_nettype wire

// ===== src/icymd_checker.sv =====
`default_nettype none
module icymd_checker
  import icymd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_is_payload,
  input wire logic [2:0] out_phase_code,
  input wire logic       out_header_end
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_is_payload) && $stable(out_phase_code) && $stable(out_header_end))
    else $error("stalled result beat changed");

  // terminator is a dropped header byte
  a_hend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_header_end |-> out_phase_code == CODE_HEADER && !out_is_payload)
    else $error("header_end outside header phase");

  // only audio bytes are forwarded
  a_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_payload |-> out_phase_code == CODE_AUDIO)
    else $error("payload flag on non-audio byte");

  // input backpressure only follows a stalled full output
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall without output backpressure");

endmodule

bind icy_metadata_stripper icymd_checker u_icymd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_is_payload (out_is_payload),
  .out_phase_code (out_phase_code),
  .out_header_end (out_header_end)
);
`default_nettype wire

// ===== verif/tb_icy_metadata_stripper.sv =====
module tb_icy_metadata_stripper;
  timeunit 1ns;
  timeprecision 1ps;
  import icymd_pkg::*;

  // Short header limit keeps the header boundary test to a few hundred beats
  localparam int HDR_LIMIT = 256;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT-facing signals (all driven to known values at time 0)
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_byte = '0;

  logic              out_valid;
  logic              out_stall = 1'b1;
  logic [7:0]        out_byte;
  logic              out_is_payload;
  logic [2:0]        out_phase_code;
  logic              out_header_end;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  always #2 clk = ~clk;

  icy_metadata_stripper #(
    .HEADER_LIMIT (HDR_LIMIT)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_is_payload (out_is_payload),
    .out_phase_code (out_phase_code),
    .out_header_end (out_header_end),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // ---------------------------------------------------------------------------
  // Deframer prediction state. Mirrors the block after reset; advanced once per
  // accepted input beat, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [23:0] interval_q   = '0;          // meta_interval as last written
  logic [2:0]  phase_q      = CODE_HEADER;
  int          crlf_q       = 0;           // progress through CR LF CR LF
  int          hdr_count_q  = 0;           // header bytes counted so far
  logic [23:0] audio_left_q = '0;
  logic [11:0] meta_left_q  = '0;

  icymd_res_t  deframed_q[$];              // predicted results, oldest first

  int errors      = 0;
  int tx_idle_pct = 0;                     // chance the sender skips a cycle
  int rx_idle_pct = 0;                     // chance the receiver stalls a cycle
  int hold_left   = 0;                     // forced receiver stall, in cycles

  // Classify one byte and advance the prediction state.
  function automatic icymd_res_t deframe_byte(input logic [7:0] b);
    icymd_res_t r;
    r.data    = b;
    r.payload = 1'b0;
    r.code    = phase_q;
    r.hend    = 1'b0;
    case (phase_q)
      CODE_HEADER: begin
        r.code = CODE_HEADER;
        if (b == CH_CR && (crlf_q == 0 || crlf_q == 2)) crlf_q++;
        else if (b == CH_LF && (crlf_q == 1 || crlf_q == 3)) crlf_q++;
        else crlf_q = 0;
        if (crlf_q == 4) begin
          // terminator wins even on the byte past the limit
          r.hend       = 1'b1;
          crlf_q       = 0;
          phase_q      = CODE_AUDIO;
          audio_left_q = interval_q;
        end else if (hdr_count_q >= HDR_LIMIT) begin
          r.code  = CODE_ERROR;
          phase_q = CODE_ERROR;
        end else begin
          hdr_count_q++;
        end
      end
      CODE_ERROR: begin
        r.code = CODE_ERROR;
      end
      default: begin
        if (interval_q == '0) begin
          // stripping off: pass through, drop any block in progress
          r.code      = CODE_AUDIO;
          r.payload   = 1'b1;
          phase_q     = CODE_AUDIO;
          meta_left_q = '0;
        end else if (phase_q == CODE_AUDIO) begin
          if (audio_left_q == '0) begin
            r.code      = CODE_LEN;
            meta_left_q = {b, 4'b0000};
            if (meta_left_q == '0) begin
              audio_left_q = interval_q;
              phase_q      = CODE_AUDIO;
            end else begin
              phase_q = CODE_META;
            end
          end else begin
            r.code       = CODE_AUDIO;
            r.payload    = 1'b1;
            audio_left_q = audio_left_q - 24'd1;
          end
        end else begin
          r.code = CODE_META;
          if (meta_left_q != '0) meta_left_q = meta_left_q - 12'd1;
          if (meta_left_q == '0) begin
            audio_left_q = interval_q;
            phase_q      = CODE_AUDIO;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Body stimulus: random audio/metadata content, but length bytes are kept
  // mostly short so the stream keeps cycling through whole metadata blocks.
  function automatic logic [7:0] pick_body_byte();
    int roll;
    roll = $urandom_range(99);
    if (phase_q == CODE_AUDIO && interval_q != '0 && audio_left_q == '0) begin
      if (roll < 60) return 8'($urandom_range(2));
      if (roll < 97) return 8'($urandom_range(15, 3));
      return 8'($urandom_range(255));
    end
    return 8'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one beat per call, random idle cycles ahead of it.
  // Called and returns at a falling edge; valid stays high into the next call.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    deframed_q.push_back(deframe_byte(b));
    @(negedge clk);
  endtask

  // Stop offering and wait for every predicted result to come back.
  task automatic wait_stream_empty();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (deframed_q.size() != 0 && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    if (deframed_q.size() != 0) begin
      $error("%0d predicted results never arrived", deframed_q.size());
      errors++;
      deframed_q.delete();
    end
  endtask

  // APB write of meta_interval with junk in the unused top bits, then a
  // read back. Only done with the stream drained.
  task automatic write_interval(input logic [23:0] v);
    logic [7:0] junk;
    junk = 8'($urandom_range(255));
    wait_stream_empty();
    repeat (2) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_META_INTERVAL;
    pwdata  <= {junk, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    interval_q = v;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[23:0] !== v) begin
      $error("meta_interval: expected %0d, got %0d", v, prdata[23:0]);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, plus a forced hold-off counted down here.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Every accepted result beat is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    icymd_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (deframed_q.size() == 0) begin
        $error("unexpected result beat: out_byte %02h", out_byte);
        errors++;
      end else begin
        want = deframed_q.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_byte);
          errors++;
        end
        if (out_is_payload !== want.payload) begin
          $error("out_is_payload: expected %0b, got %0b", want.payload, out_is_payload);
          errors++;
        end
        if (out_phase_code !== want.code) begin
          $error("out_phase_code: expected %0d, got %0d", want.code, out_phase_code);
          errors++;
        end
        if (out_header_end !== want.hend) begin
          $error("out_header_end: expected %0b, got %0b", want.hend, out_header_end);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Header: partial terminators that must clear the match, extreme bytes,
  // then filler so the final LF is exactly the byte past the header limit.
  task automatic test_header_boundary();
    logic [7:0] opening [12];
    logic [7:0] fill;
    // LF with no CR; CR at one; CR LF LF; CR LF CR CR; extremes
    opening = '{CH_LF, CH_CR, CH_CR, CH_CR, CH_LF, CH_LF,
                CH_CR, CH_LF, CH_CR, CH_CR, 8'h00, 8'hFF};
    foreach (opening[i]) send_byte(opening[i]);
    while (hdr_count_q < HDR_LIMIT - 4) begin
      fill = 8'($urandom_range(255));
      if (crlf_q == 3 && fill == CH_LF) fill = 8'h00;   // no early terminator
      send_byte(fill);
    end
    send_byte(8'h00);                                    // match back to zero
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(CH_LF);                                    // count == limit here
  endtask

  // Body with interval 1: zero length byte, one full block, a block cut off
  // by disabling stripping, then stripping enabled with audio_left at zero.
  task automatic test_directed_body();
    send_byte(8'h00);                   // audio
    send_byte(8'h00);                   // zero length, no metadata
    send_byte(8'hFF);                   // audio
    send_byte(8'h01);                   // length 1 -> 16 metadata bytes
    for (int i = 0; i < 16; i++) send_byte(i[0] ? 8'hFF : 8'h00);
    send_byte(8'h5A);                   // audio
    send_byte(8'h02);                   // length 2 -> 32 metadata bytes
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(8'hFF);
    write_interval(24'd0);              // abandon the block mid-way
    send_byte(CH_CR);
    send_byte(CH_LF);
    write_interval(24'd1);              // next body byte is a length byte
    send_byte(8'h00);
    send_byte(8'h80);
  endtask

  // Random body content across interval settings, extremes included.
  task automatic test_random_stream(input int n_bytes);
    logic [23:0] v;
    int first;
    first = $urandom_range(5);
    for (int c = 0; c < 6; c++) begin
      case ((first + c) % 6)
        0: v = 24'd0;
        1: v = 24'd1;
        2: v = 24'($urandom_range(48, 2));
        3: v = 24'hFFFFFF;
        4: v = 24'($urandom);
        default: v = 24'($urandom_range(8, 1));
      endcase
      write_interval(v);
      repeat (n_bytes / 6) send_byte(pick_body_byte());
    end
  endtask

  // Receiver holds off long enough for the block to fill and stall its
  // input while the sender keeps offering; then the sender waits it out.
  task automatic test_backpressure();
    int saved_tx;
    saved_tx = tx_idle_pct;
    write_interval(24'($urandom_range(6, 2)));
    tx_idle_pct = 0;
    hold_left   = 300;
    repeat (60) send_byte(pick_body_byte());
    wait_stream_empty();
    tx_idle_pct = saved_tx;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sender sparse, receiver busy
    tx_idle_pct = 34;
    rx_idle_pct = 76;
    write_interval(24'd1);
    test_header_boundary();
    test_directed_body();
    test_random_stream(360);

    // roles swapped
    tx_idle_pct = 76;
    rx_idle_pct = 34;
    test_random_stream(360);
    test_backpressure();

    // full rate both ways
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_stream(366);

    wait_stream_empty();
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("PASS icy_metadata_stripper");
    end else begin
      $display("FAIL icy_metadata_stripper");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("FAIL icy_metadata_stripper");
    $finish;
  end

endmodule
